@@ rtl/qtt_pkg.sv @@
package qtt_pkg;

    localparam int unsigned POS_W        = 16;
    localparam int unsigned LEN_W        = 16;
    localparam logic [POS_W-1:0] MAX_TEXT_LEN = 16'hFFFF;
    localparam int unsigned QUEUE_DEPTH  = 3;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_HASH   = 8'h23;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_CMP  = 2'd2
    } t_scan_mode;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_OP   = 2'd1,
        KIND_CMP  = 2'd2
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind         kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic [7:0]        op_char;
        logic              run_end;
    } t_token;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]});
    endfunction

    function automatic logic is_single_op(input logic [7:0] c);
        return (c inside {CH_LPAREN, CH_RPAREN, CH_PLUS, CH_STAR,
                          CH_SLASH, CH_MINUS, CH_EQUAL, CH_QUOTE});
    endfunction

    function automatic logic is_word_cont(input logic [7:0] c);
        return is_alnum(c) || (c == CH_UNDER) || (c == CH_HASH);
    endfunction

    // A length of zero can only come from a saturated position and reads as one.
    function automatic logic [LEN_W-1:0] sat_len(input logic [POS_W:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v[POS_W]) begin
            r = '1;
        end else begin
            r = v[LEN_W-1:0];
        end
        return r;
    endfunction

    function automatic t_token mk_token(input t_tok_kind kind,
                                        input logic [POS_W-1:0] start,
                                        input logic [LEN_W-1:0] length,
                                        input logic [7:0] op_char);
        t_token t;
        t.kind    = kind;
        t.start   = start;
        t.length  = length;
        t.op_char = op_char;
        t.run_end = 1'b0;
        return t;
    endfunction

endpackage

@@ rtl/query_text_tokenizer_top.sv @@
// Query text tokenizer. Text arrives one byte per transaction, the last byte of a text
// flagged by i_final_byte; tokens leave one per transaction with kind, start position,
// length and operator character, and o_run_end marks the last token caused by a byte.
// Each byte is registered, then scanned, and its tokens enter a three-entry token queue
// that decouples the two sides and whose head is offered. One byte is taken every cycle
// as long as each byte causes at most one token and the output is not stalled; a byte
// that causes two tokens occupies the single token port for both, which sets the rate
// at that point. Input stalls while two or more tokens are waiting.
module query_text_tokenizer_top
    import qtt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_text_byte,
    input  logic             i_final_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_token_kind,
    output logic [POS_W-1:0] o_token_start,
    output logic [LEN_W-1:0] o_token_length,
    output logic [7:0]       o_operator_char,
    output logic             o_run_end
);

    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_fin;

    t_scan_mode       r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_wb, n_wb;
    logic [7:0]       r_pend, n_pend;

    t_token           r_q [QUEUE_DEPTH];
    t_token           n_q [QUEUE_DEPTH];
    logic [1:0]       r_cnt, n_cnt;

    logic             process;
    logic             pop;
    logic [1:0]       base;
    logic             va, vb, vc;
    t_token           ta, tb, tc;
    t_token           e0, e1;
    logic [1:0]       ecnt;

    assign pop     = o_valid && !i_stall;
    assign process = r_in_valid && (r_cnt <= 2'd1);
    assign o_stall = r_in_valid && (r_cnt > 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_text_byte;
            r_fin  <= i_final_byte;
        end
    end

    always_comb begin
        logic [7:0]       c;
        logic             do_disp;
        t_token           t0, t1;
        c       = r_byte;
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_wb    = r_wb;
        n_pend  = r_pend;
        do_disp = 1'b0;
        va      = 1'b0;
        vb      = 1'b0;
        vc      = 1'b0;
        ta      = mk_token(KIND_WORD, r_wb, sat_len({1'b0, r_pos} - {1'b0, r_wb}), 8'd0);
        tb      = mk_token(KIND_OP, r_pos, LEN_W'(1), c);
        tc      = ta;

        case (r_mode)
            MODE_WORD: begin
                if (!is_word_cont(c)) begin
                    va      = 1'b1;
                    n_mode  = MODE_IDLE;
                    do_disp = 1'b1;
                end
            end
            MODE_CMP: begin
                n_mode = MODE_IDLE;
                va     = 1'b1;
                if (c == CH_EQUAL) begin
                    ta = mk_token(KIND_CMP, r_wb, LEN_W'(2), r_pend);
                end else begin
                    ta      = mk_token(KIND_OP, r_wb, LEN_W'(1), r_pend);
                    do_disp = 1'b1;
                end
            end
            default: begin
                n_mode  = MODE_IDLE;
                do_disp = 1'b1;
            end
        endcase

        if (do_disp) begin
            if (is_single_op(c)) begin
                vb = 1'b1;
            end else if (c == CH_LT || c == CH_GT) begin
                n_mode = MODE_CMP;
                n_pend = c;
                n_wb   = r_pos;
            end else if (is_alnum(c)) begin
                n_mode = MODE_WORD;
                n_wb   = r_pos;
            end
        end

        if (r_fin) begin
            if (n_mode == MODE_WORD) begin
                vc = 1'b1;
                tc = mk_token(KIND_WORD, n_wb,
                              sat_len({1'b0, r_pos} + (POS_W+1)'(1) - {1'b0, n_wb}), 8'd0);
            end else if (n_mode == MODE_CMP) begin
                vc = 1'b1;
                tc = mk_token(KIND_OP, n_wb, LEN_W'(1), n_pend);
            end
            n_mode = MODE_IDLE;
            n_pos  = '0;
        end else if (r_pos < MAX_TEXT_LEN) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = MAX_TEXT_LEN;
        end

        t0 = va ? ta : (vb ? tb : tc);
        t1 = (va && vb) ? tb : tc;
        ecnt = 2'(va) + 2'(vb) + 2'(vc);
        t0.run_end = (ecnt == 2'd1);
        t1.run_end = 1'b1;
        e0 = t0;
        e1 = t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pos  <= '0;
            r_wb   <= '0;
            r_pend <= '0;
        end else if (process) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_wb   <= n_wb;
            r_pend <= n_pend;
        end
    end

    always_comb begin
        t_token shifted [QUEUE_DEPTH];
        logic [2:0] top;
        base = pop ? (r_cnt - 2'd1) : r_cnt;
        top  = {1'b0, base} + (process ? {1'b0, ecnt} : 3'd0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && (i < QUEUE_DEPTH - 1)) begin
                shifted[i] = r_q[i+1];
            end else begin
                shifted[i] = r_q[i];
            end
            if (3'(i) < {1'b0, base} || 3'(i) >= top) begin
                n_q[i] = shifted[i];
            end else if (3'(i) == {1'b0, base}) begin
                n_q[i] = e0;
            end else begin
                n_q[i] = e1;
            end
        end
        n_cnt = top[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_valid         = (r_cnt != 2'd0);
    assign o_token_kind    = r_q[0].kind;
    assign o_token_start   = r_q[0].start;
    assign o_token_length  = r_q[0].length;
    assign o_operator_char = r_q[0].op_char;
    assign o_run_end       = r_q[0].run_end;

    a_fin_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_fin) |=> (r_pos == '0 && r_mode == MODE_IDLE))
        else $error("Position or scan mode not cleared after the final byte.");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process |-> ({1'b0, base} + {1'b0, ecnt} <= 3'(QUEUE_DEPTH)))
        else $error("Token queue overflow.");

    a_word_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind == KIND_WORD) |->
            (o_operator_char == 8'd0 && o_token_length != '0))
        else $error("Malformed word token.");

    a_pos_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && !r_fin && r_pos != MAX_TEXT_LEN) |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("Byte position did not advance.");

endmodule
